// ===== hw/rtl/opaque_pixel_bounding_box_assert.svh =====
// assertion macros shared by the bounding box checker
`ifndef OPAQUE_PIXEL_BOUNDING_BOX_ASSERT_SVH
`define OPAQUE_PIXEL_BOUNDING_BOX_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define OPBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("opbb assertion failed");

// next-cycle implication, disabled while in reset
`define OPBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("opbb assertion failed");

`endif

// ===== hw/rtl/opbb_pkg.sv =====
// ----------------------------------------------------------------------------
// opbb_pkg
// Shared types and register codes of the opaque pixel bounding box block.
// ----------------------------------------------------------------------------
package opbb_pkg;

    // configuration port widths
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int SizeW    = 11;
    localparam int PixelW   = 16;

    // result field widths
    localparam int PosW = 10;
    localparam int LenW = 11;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY_COLOR    = 2'd2;

    // register reset values
    localparam logic [SizeW-1:0]  FRAME_WIDTH_RST  = 11'd320;
    localparam logic [SizeW-1:0]  FRAME_HEIGHT_RST = 11'd240;
    localparam logic [PixelW-1:0] KEY_COLOR_RST    = 16'd0;

    typedef logic [CfgIdxW-1:0]  t_cfg_idx;
    typedef logic [CfgDataW-1:0] t_cfg_data;
    typedef logic [SizeW-1:0]    t_size;
    typedef logic [PixelW-1:0]   t_pixel;

    // one frame result
    typedef struct packed {
        logic            empty_res;
        logic            whole_frame;
        logic [PosW-1:0] box_left;
        logic [PosW-1:0] box_top;
        logic [LenW-1:0] box_width;
        logic [LenW-1:0] box_height;
    } t_frame_res;

endpackage

// ===== hw/rtl/opaque_pixel_bounding_box.sv =====
// Result: a frame result becomes valid in the cycle after its last pixel item is accepted.
// Throughput: one pixel item per cycle; the tracker updates position and box for each
// accepted item; the input stalls only while a result waits on a held-off receiver.
// Reset: synchronous active-low; clears counters, box and result valid, restores
// frame size 320 x 240 and key color 0, and drops a partly received frame.
// ----------------------------------------------------------------------------
// opaque_pixel_bounding_box
// Bounding box of non-transparent pixels over a raster frame, one result per
// frame.
// ----------------------------------------------------------------------------
module opaque_pixel_bounding_box #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  opbb_pkg::t_pixel      i_pixel,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_empty_res,
    output logic                  o_whole_frame,
    output logic [9:0]            o_box_left,
    output logic [9:0]            o_box_top,
    output logic [10:0]           o_box_width,
    output logic [10:0]           o_box_height,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  opbb_pkg::t_cfg_idx    i_cfg_index,
    input  opbb_pkg::t_cfg_data   i_cfg_data
);
    import opbb_pkg::*;

    t_size      r_frame_w, r_frame_h;
    t_pixel     r_key;
    logic       r_out_valid, n_out_valid;
    t_frame_res r_res;
    t_frame_res trk_res;
    logic       step, done;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_WIDTH_RST;
            r_frame_h <= FRAME_HEIGHT_RST;
            r_key     <= KEY_COLOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_w <= i_cfg_data[SizeW-1:0];
                REG_FRAME_HEIGHT: r_frame_h <= i_cfg_data[SizeW-1:0];
                REG_KEY_COLOR:    r_key     <= i_cfg_data[PixelW-1:0];
                default: begin
                end
            endcase
        end
    end

    // accept an item unless a result is stuck in the output register
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    opbb_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_pixel   (i_pixel),
        .i_frame_w (r_frame_w),
        .i_frame_h (r_frame_h),
        .i_key     (r_key),
        .o_done    (done),
        .o_res     (trk_res)
    );

    // result register
    always_comb begin
        if (done) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_res <= trk_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_empty_res   = r_res.empty_res;
    assign o_whole_frame = r_res.whole_frame;
    assign o_box_left    = r_res.box_left;
    assign o_box_top     = r_res.box_top;
    assign o_box_width   = r_res.box_width;
    assign o_box_height  = r_res.box_height;

endmodule

// ===== hw/rtl/opbb_tracker.sv =====
// ----------------------------------------------------------------------------
// opbb_tracker
// Raster position counters and running box; forms the frame result on the
// last pixel of a frame.
// ----------------------------------------------------------------------------
module opbb_tracker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  opbb_pkg::t_pixel     i_pixel,
    input  opbb_pkg::t_size      i_frame_w,
    input  opbb_pkg::t_size      i_frame_h,
    input  opbb_pkg::t_pixel     i_key,
    output logic                 o_done,
    output opbb_pkg::t_frame_res o_res
);
    import opbb_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WSW  = (CW + 1 > SizeW) ? CW + 1 : SizeW;
    localparam int HSW  = (RW + 1 > SizeW) ? RW + 1 : SizeW;
    localparam logic [WSW-1:0] MaxW = WSW'(MAX_WIDTH);
    localparam logic [HSW-1:0] MaxH = HSW'(MAX_HEIGHT);

    logic [CW-1:0] r_col, n_col, r_lc, n_lc, r_gc, n_gc;
    logic [RW-1:0] r_row, n_row, r_lr, n_lr, r_gr, n_gr;
    logic          r_found, n_found;

    logic [WSW-1:0] fw_ext, w_full;
    logic [HSW-1:0] fh_ext, h_full;
    logic [CW:0]    w_eff, col_inc, bw;
    logic [RW:0]    h_eff, row_inc, bh;
    logic           opaque, col_last, row_last;
    logic [CW-1:0]  b_lc, b_gc;
    logic [RW-1:0]  b_lr, b_gr;
    logic           b_found;
    logic [31:0]    left_x, top_x, bw_x, bh_x;

    // effective frame size: zero acts as one, saturate at the maximum
    always_comb begin
        fw_ext = WSW'(i_frame_w);
        fh_ext = HSW'(i_frame_h);
        if (fw_ext == '0) begin
            w_full = WSW'(1);
        end else if (fw_ext > MaxW) begin
            w_full = MaxW;
        end else begin
            w_full = fw_ext;
        end
        if (fh_ext == '0) begin
            h_full = HSW'(1);
        end else if (fh_ext > MaxH) begin
            h_full = MaxH;
        end else begin
            h_full = fh_ext;
        end
        w_eff = w_full[CW:0];
        h_eff = h_full[RW:0];
    end

    // end of row and end of frame
    assign col_inc  = (CW+1)'(r_col) + (CW+1)'(1);
    assign row_inc  = (RW+1)'(r_row) + (RW+1)'(1);
    assign col_last = !(col_inc < w_eff);
    assign row_last = !(row_inc < h_eff);
    assign opaque   = (i_pixel != i_key);

    // box including the current pixel
    always_comb begin
        b_found = r_found;
        b_lc    = r_lc;
        b_gc    = r_gc;
        b_lr    = r_lr;
        b_gr    = r_gr;
        if (opaque) begin
            b_found = 1'b1;
            if (!r_found) begin
                b_lc = r_col;
                b_gc = r_col;
                b_lr = r_row;
                b_gr = r_row;
            end else begin
                if (r_col < r_lc) b_lc = r_col;
                if (r_col > r_gc) b_gc = r_col;
                if (r_row < r_lr) b_lr = r_row;
                if (r_row > r_gr) b_gr = r_row;
            end
        end
    end

    // next state
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_found = r_found;
        n_lc    = r_lc;
        n_gc    = r_gc;
        n_lr    = r_lr;
        n_gr    = r_gr;
        if (i_step) begin
            n_found = b_found;
            n_lc    = b_lc;
            n_gc    = b_gc;
            n_lr    = b_lr;
            n_gr    = b_gr;
            if (!col_last) begin
                n_col = col_inc[CW-1:0];
            end else begin
                n_col = '0;
                if (!row_last) begin
                    n_row = row_inc[RW-1:0];
                end else begin
                    n_row   = '0;
                    n_found = 1'b0;
                    n_lc    = '0;
                    n_gc    = '0;
                    n_lr    = '0;
                    n_gr    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_found <= 1'b0;
            r_lc    <= '0;
            r_gc    <= '0;
            r_lr    <= '0;
            r_gr    <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_found <= n_found;
            r_lc    <= n_lc;
            r_gc    <= n_gc;
            r_lr    <= n_lr;
            r_gr    <= n_gr;
        end
    end

    // frame result
    assign bw     = (CW+1)'(b_gc) - (CW+1)'(b_lc) + (CW+1)'(1);
    assign bh     = (RW+1)'(b_gr) - (RW+1)'(b_lr) + (RW+1)'(1);
    assign left_x = 32'(b_lc);
    assign top_x  = 32'(b_lr);
    assign bw_x   = 32'(bw);
    assign bh_x   = 32'(bh);
    assign o_done = i_step && col_last && row_last;

    always_comb begin
        if (!b_found) begin
            o_res.empty_res   = 1'b1;
            o_res.whole_frame = 1'b0;
            o_res.box_left    = '0;
            o_res.box_top     = '0;
            o_res.box_width   = '0;
            o_res.box_height  = '0;
        end else begin
            o_res.empty_res   = 1'b0;
            o_res.whole_frame = (bw == w_eff) && (bh == h_eff);
            o_res.box_left    = left_x[PosW-1:0];
            o_res.box_top     = top_x[PosW-1:0];
            o_res.box_width   = bw_x[LenW-1:0];
            o_res.box_height  = bh_x[LenW-1:0];
        end
    end

endmodule

// ===== hw/rtl/opbb_checker.sv =====
// ----------------------------------------------------------------------------
// opbb_checker
// Port-level checks of the bounding box block, bound to the top level.
// ----------------------------------------------------------------------------
module opbb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_empty_res,
    input logic        o_whole_frame,
    input logic [9:0]  o_box_left,
    input logic [9:0]  o_box_top,
    input logic [10:0] o_box_width,
    input logic [10:0] o_box_height
);
`include "opaque_pixel_bounding_box_assert.svh"

    logic        geom_zero;
    logic        box_nonzero;
    logic        out_stall;
    logic [43:0] out_fields;

    // helper terms for the checks
    assign geom_zero   = !o_whole_frame && o_box_left == 10'd0 && o_box_top == 10'd0
                         && o_box_width == 11'd0 && o_box_height == 11'd0;
    assign box_nonzero = o_box_width != 11'd0 && o_box_height != 11'd0;
    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_fields  = {o_empty_res, o_whole_frame, o_box_left, o_box_top,
                          o_box_width, o_box_height};

    // an empty frame reports no geometry
    `OPBB_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_out_valid && o_empty_res, geom_zero)

    // a non-empty box is at least one pixel in each direction
    `OPBB_ASSERT_IMPLY(a_box_size, i_clk, i_rst_n, o_out_valid && !o_empty_res, box_nonzero)

    // a whole-frame box is never empty
    `OPBB_ASSERT_IMPLY(a_whole_nonempty, i_clk, i_rst_n, o_out_valid && o_whole_frame, !o_empty_res)

    // input stays open while no result waits
    `OPBB_ASSERT_IMPLY(a_ready_free, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready)

    // a stalled result holds
    `OPBB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_fields))

endmodule

bind opaque_pixel_bounding_box opbb_checker u_opbb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_empty_res   (o_empty_res),
    .o_whole_frame (o_whole_frame),
    .o_box_left    (o_box_left),
    .o_box_top     (o_box_top),
    .o_box_width   (o_box_width),
    .o_box_height  (o_box_height)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the opaque pixel bounding box. Pixel frames of many
// sizes and key colors are streamed through the input channel while both
// channels idle and stall at random. Every frame result is compared with a
// box computed on the side from the accepted pixels.
// ----------------------------------------------------------------------------
module tb;
    import opbb_pkg::*;

    localparam int IdleLimit = 2000;

    // box tracker and store of expected frame boxes
    class bbox_scoreboard;
        localparam int MaxWidth  = 1024;
        localparam int MaxHeight = 1024;

        t_size      frame_width;
        t_size      frame_height;
        t_pixel     key_color;
        logic [9:0] column;
        logic [9:0] row;
        logic       found_any;
        logic [9:0] least_col;
        logic [9:0] least_row;
        logic [9:0] great_col;
        logic [9:0] great_row;
        t_frame_res expected_boxes[$];
        int         mismatches;

        static function int effective_size(int v, int limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function void clear_frame();
            column    = '0;
            row       = '0;
            found_any = 1'b0;
            least_col = '0;
            least_row = '0;
            great_col = '0;
            great_row = '0;
        endfunction

        function void reset_state();
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            key_color    = KEY_COLOR_RST;
            mismatches   = 0;
            expected_boxes.delete();
            clear_frame();
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                REG_FRAME_WIDTH:  frame_width  = data[SizeW-1:0];
                REG_FRAME_HEIGHT: frame_height = data[SizeW-1:0];
                REG_KEY_COLOR:    key_color    = data[PixelW-1:0];
                default: ;
            endcase
        endfunction

        // advance position, grow the box, close the frame on its last pixel
        function void note_pixel(t_pixel pix);
            int         w;
            int         h;
            t_frame_res box;
            w = effective_size(int'(frame_width), MaxWidth);
            h = effective_size(int'(frame_height), MaxHeight);
            if (pix != key_color) begin
                if (!found_any) begin
                    found_any = 1'b1;
                    least_col = column;
                    great_col = column;
                    least_row = row;
                    great_row = row;
                end else begin
                    if (column < least_col) least_col = column;
                    if (column > great_col) great_col = column;
                    if (row < least_row) least_row = row;
                    if (row > great_row) great_row = row;
                end
            end
            if (int'(column) + 1 < w) begin
                column = column + 10'd1;
                return;
            end
            column = '0;
            if (int'(row) + 1 < h) begin
                row = row + 10'd1;
                return;
            end
            box = '0;
            if (!found_any) begin
                box.empty_res = 1'b1;
            end else begin
                box.box_left    = least_col;
                box.box_top     = least_row;
                box.box_width   = {1'b0, great_col} - {1'b0, least_col} + 11'd1;
                box.box_height  = {1'b0, great_row} - {1'b0, least_row} + 11'd1;
                box.whole_frame = (int'(box.box_width) == w) && (int'(box.box_height) == h);
            end
            expected_boxes.push_back(box);
            clear_frame();
        endfunction

        function void report(string what, t_frame_res want, t_frame_res got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch (%s) at %0t: expected e=%0d wf=%0d l=%0d t=%0d w=%0d h=%0d",
                         what, $time, want.empty_res, want.whole_frame, want.box_left,
                         want.box_top, want.box_width, want.box_height);
                $display("    actual e=%0d wf=%0d l=%0d t=%0d w=%0d h=%0d",
                         got.empty_res, got.whole_frame, got.box_left, got.box_top,
                         got.box_width, got.box_height);
            end
        endfunction

        function void check_result(t_frame_res got);
            t_frame_res want;
            if (expected_boxes.size() == 0) begin
                report("no frame pending", '0, got);
                return;
            end
            want = expected_boxes.pop_front();
            if (got !== want) report("box", want, got);
        endfunction

        function int pending();
            return expected_boxes.size();
        endfunction

        function int failures();
            return mismatches + expected_boxes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_pixel      i_pixel;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_empty_res;
    logic        o_whole_frame;
    logic [9:0]  o_box_left;
    logic [9:0]  o_box_top;
    logic [10:0] o_box_width;
    logic [10:0] o_box_height;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    t_cfg_data   i_cfg_data;

    bbox_scoreboard sb;
    bit calm;
    bit hold_request;
    int pixels_sent;

    opaque_pixel_bounding_box i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_empty_res  (o_empty_res),
        .o_whole_frame(o_whole_frame),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one pixel item, with a random gap ahead of it unless calm
    task automatic send_pixel(input t_pixel pix);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 19) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(pix);
        pixels_sent++;
    endtask

    // stop the input and let every pending frame result drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // write all three registers back to back
    task automatic program_frame(input t_cfg_data wdata, input t_cfg_data hdata,
                                 input t_cfg_data kdata);
        t_cfg_idx  idx [3];
        t_cfg_data data [3];
        idx  = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_KEY_COLOR};
        data = '{wdata, hdata, kdata};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= data[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[i], data[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // key pixel, or an opaque one with the given chance in percent
    function automatic t_pixel pick_pixel(t_pixel key, int density);
        if ($urandom_range(0, 99) >= density) return key;
        if ($urandom_range(0, 2) == 0) return key ^ (16'h1 << $urandom_range(0, 15));
        return t_pixel'($urandom_range(0, 65535));
    endfunction

    task automatic stream_pixels(input int count, input int density, input t_pixel key,
                                 input bit opaque_ends);
        t_pixel pix;
        for (int i = 0; i < count; i++) begin
            pix = pick_pixel(key, density);
            if (opaque_ends && (i == 0 || i == count - 1)) pix = key ^ 16'h8000;
            send_pixel(pix);
        end
    endtask

    // result side: random ready, plus one long hold-off on request
    initial begin
        t_frame_res got;
        int         hold_left;
        bit         rdy;
        hold_left = 0;
        forever begin
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 60;
                rdy          = 1'b0;
            end else begin
                rdy = calm || ($urandom_range(0, 99) >= 19);
            end
            i_out_ready <= rdy;
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.empty_res   = o_empty_res;
                got.whole_frame = o_whole_frame;
                got.box_left    = o_box_left;
                got.box_top     = o_box_top;
                got.box_width   = o_box_width;
                got.box_height  = o_box_height;
                sb.check_result(got);
            end
        end
    end

    // watchdog on cycles with no item moving on any channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int     w;
        int     h;
        int     wc;
        int     hc;
        int     count;
        int     density;
        int     phase;
        int     random_base;
        t_pixel key;

        sb = new();
        sb.reset_state();
        calm         = 1'b0;
        hold_request = 1'b0;
        pixels_sent  = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pixel     <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero sizes act as one: every pixel is a frame
        program_frame(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
        settle();

        // all-ones key, opaque corners span the frame
        program_frame(16'd3, 16'd2, 16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h1234);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        settle();

        // width shrinks mid-frame below the current column
        program_frame(16'd4, 16'd3, 16'h5A5A);
        send_pixel(16'h5A5A);
        send_pixel(16'h5A5A);
        send_pixel(16'h5A5B);
        send_pixel(16'h5A5A);
        send_pixel(16'h5A5A);
        send_pixel(16'hA5A5);
        settle();
        program_frame(16'd2, 16'd3, 16'h5A5A);
        send_pixel(16'h5A5A);
        send_pixel(16'hDA5A);
        send_pixel(16'h5A5A);
        settle();

        // height shrinks mid-frame below the current row
        program_frame(16'd2, 16'd4, 16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0400);
        settle();
        program_frame(16'd2, 16'd2, 16'h0000);
        send_pixel(16'h0000);
        settle();

        // oversized height saturates, then a smaller height ends the frame at once
        program_frame(16'd1, 16'h07FF, 16'h0000);
        stream_pixels(6, 50, 16'h0000, 1'b1);
        settle();
        program_frame(16'd1, 16'd4, 16'h0000);
        send_pixel(16'h0000);
        settle();

        // widest row: oversized width saturates, opaque first and last pixel
        key = t_pixel'($urandom_range(0, 65535));
        program_frame(16'hFFFF, 16'hF800, key);
        stream_pixels(1024, 3, key, 1'b1);
        settle();

        // tall column of one pixel per row
        key = t_pixel'($urandom_range(0, 65535));
        program_frame(16'h0801, 16'd160, key);
        stream_pixels(160, 3, key, 1'b0);
        settle();

        // random frames, some cut short by the next size change
        random_base = pixels_sent;
        phase       = 0;
        while (pixels_sent - random_base < 330) begin
            calm = (pixels_sent - random_base >= 100) && (pixels_sent - random_base < 200);
            settle();
            case ($urandom_range(0, 2))
                0:       key = 16'h0000;
                1:       key = 16'hFFFF;
                default: key = t_pixel'($urandom_range(0, 65535));
            endcase
            if (phase == 0) begin
                // receiver holds off while one-pixel frames keep coming
                program_frame(t_cfg_data'({5'($urandom_range(0, 31)), 11'd0}),
                              t_cfg_data'({5'($urandom_range(0, 31)), 11'd0}), key);
                calm         = 1'b1;
                hold_request = 1'b1;
                stream_pixels(120, 50, key, 1'b0);
                calm = 1'b0;
            end else begin
                count = $urandom_range(0, 99);
                if (count < 70) begin
                    w = $urandom_range(1, 6);
                    h = $urandom_range(1, 6);
                end else if (count < 85) begin
                    w = $urandom_range(7, 40);
                    h = $urandom_range(1, 3);
                end else if (count < 93) begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(7, 40);
                end else begin
                    w = 0;
                    h = $urandom_range(0, 5);
                end
                program_frame(t_cfg_data'({5'($urandom_range(0, 31)), 11'(w)}),
                              t_cfg_data'({5'($urandom_range(0, 31)), 11'(h)}), key);
                wc    = bbox_scoreboard::effective_size(w, bbox_scoreboard::MaxWidth);
                hc    = bbox_scoreboard::effective_size(h, bbox_scoreboard::MaxHeight);
                count = $urandom_range(1, 3) * wc * hc;
                if ($urandom_range(0, 3) == 0) count += $urandom_range(0, wc * hc);
                case ($urandom_range(0, 4))
                    0:       density = 0;
                    1:       density = 100;
                    default: density = $urandom_range(1, 60);
                endcase
                stream_pixels(count, density, key, 1'b0);
            end
            phase++;
        end
        calm = 1'b0;

        // drain and report
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.failures() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
